### hw/rtl/phaser_pkg.sv
// ----------------------------------------------------------------------------
// phaser_pkg
// Shared types, constants, tables and saturation helpers of the phaser.
// ----------------------------------------------------------------------------
`default_nettype none

package phaser_pkg;

  // Fixed configuration
  localparam int SAMPLE_RATE   = 48000;
  localparam int CHANNELS      = 2;
  localparam int STAGES        = 4;
  localparam int TABLE_ENTRIES = 256;

  // Field and datapath widths
  localparam int SAMPLE_W = 24;
  localparam int PHASE_W  = 32;
  localparam int MEM_W    = 28;
  localparam int COEF_W   = 18;
  localparam int OPA_W    = 28;
  localparam int OPB_W    = 18;
  localparam int PROD_W   = OPA_W + OPB_W;
  localparam int STEP_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam int KW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STG_W   = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int MEM_N   = CHANNELS * STAGES;
  localparam int MEM_AW  = (MEM_N > 1) ? $clog2(MEM_N) : 1;

  // Feedback scale 0.7 in Q0.16
  localparam int FB_SCALE = 45875;

  // Q30 angle constants
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LFO_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = 2'd2;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_ZERO,
    OP_MUL_LFO,
    OP_APPLY_LFO,
    OP_MUL_IDX,
    OP_APPLY_IDX,
    OP_MUL_G,
    OP_APPLY_G,
    OP_MUL_Y,
    OP_APPLY_Y,
    OP_MUL_Z,
    OP_APPLY_Z,
    OP_MUL_OUT,
    OP_APPLY_OUT
  } dp_op_e;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LFO_APPLY,
    ST_IDX_MUL,
    ST_IDX_APPLY,
    ST_G_MUL,
    ST_G_APPLY,
    ST_Y_MUL,
    ST_Y_APPLY,
    ST_Z_MUL,
    ST_Z_APPLY,
    ST_OUT_MUL,
    ST_OUT_APPLY,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e           op;
    logic [STG_W-1:0] stage;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic ch_ok;
  } dp_status_t;

  typedef logic signed [15:0]       sine_tab_t [TABLE_ENTRIES];
  typedef logic signed [COEF_W-1:0] coef_tab_t [TABLE_ENTRIES];

  // Restoring division, used only while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = udiv64((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'sd0 : sum;
  endfunction

  function automatic longint cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 1; n <= 7; n++) begin
      term = udiv64((term * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'sd0 : sum;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] a;
    logic        neg;
    longint      v;
    longint      q;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      a   = udiv64(64'(k) * TWO_PI_Q30, 64'(TABLE_ENTRIES));
      neg = 1'b0;
      if (a >= PI_Q30) begin
        a   = a - PI_Q30;
        neg = 1'b1;
      end
      if (a > HALF_PI_Q30) a = PI_Q30 - a;
      v = sin_q30(a);
      q = (v + 64'sd16384) >>> 15;
      if (neg) q = -q;
      if (q > 32767) q = 32767;
      tab[k] = 16'(q);
    end
    return tab;
  endfunction

  function automatic coef_tab_t build_coef();
    coef_tab_t   tab;
    logic [63:0] span;
    logic [63:0] fnum;
    logic [63:0] w;
    logic [63:0] mag;
    longint      s;
    longint      c;
    longint      den;
    longint      diff;
    longint      q;
    span = 64'(TABLE_ENTRIES - 1);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      fnum = 64'd200 * span + 64'd1500 * 64'(k);
      w    = udiv64(PI_Q30 * fnum, span * 64'(SAMPLE_RATE));
      if (w > HALF_PI_Q30) w = HALF_PI_Q30;
      s    = sin_q30(w);
      c    = cos_q30(w);
      den  = s + c;
      if (den <= 0) den = 1;
      diff = c - s;
      mag  = 64'((diff < 0) ? -diff : diff) << 16;
      q    = longint'(udiv64(mag + (64'(den) >> 1), 64'(den)));
      tab[k] = COEF_W'((diff >= 0) ? -q : q);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam coef_tab_t COEF_TAB = build_coef();

  function automatic logic signed [MEM_W-1:0] sat_mem(input logic signed [31:0] v);
    if (v > 32'sd134217727) return MEM_W'(32'sd134217727);
    if (v < -32'sd134217728) return MEM_W'(-32'sd134217728);
    return MEM_W'(v);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [31:0] v);
    if (v > 32'sd8388607) return SAMPLE_W'(32'sd8388607);
    if (v < -32'sd8388608) return SAMPLE_W'(-32'sd8388608);
    return SAMPLE_W'(v);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/phaser_ctrl.sv
// ----------------------------------------------------------------------------
// phaser_ctrl
// Sequencer: steps the shared multiplier through the LFO, coefficient, gain,
// allpass stages and output mix, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module phaser_ctrl
  import phaser_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [STG_W-1:0] stage_q, stage_d;
  logic             out_valid_q, out_valid_d;
  logic             last_stage;
  logic             out_free;

  assign last_stage = (stage_q == STG_W'(STAGES - 1));
  assign out_free   = !out_valid_q || out_ready_i;

  // Advance state
  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status_i.is_clear || !status_i.ch_ok) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LFO_APPLY;
        end
      end
      ST_LFO_APPLY: state_d = ST_IDX_MUL;
      ST_IDX_MUL:   state_d = ST_IDX_APPLY;
      ST_IDX_APPLY: state_d = ST_G_MUL;
      ST_G_MUL:     state_d = ST_G_APPLY;
      ST_G_APPLY: begin
        state_d = ST_Y_MUL;
        stage_d = '0;
      end
      ST_Y_MUL:     state_d = ST_Y_APPLY;
      ST_Y_APPLY:   state_d = ST_Z_MUL;
      ST_Z_MUL:     state_d = ST_Z_APPLY;
      ST_Z_APPLY: begin
        if (last_stage) begin
          state_d = ST_OUT_MUL;
        end else begin
          state_d = ST_Y_MUL;
          stage_d = stage_q + STG_W'(1);
        end
      end
      ST_OUT_MUL:   state_d = ST_OUT_APPLY;
      ST_OUT_APPLY: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.stage    = stage_q;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE:      cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_DISPATCH: begin
        if (status_i.is_clear) begin
          cmd_o.op = OP_CLEAR;
        end else if (!status_i.ch_ok) begin
          cmd_o.op = OP_ZERO;
        end else begin
          cmd_o.op = OP_MUL_LFO;
        end
      end
      ST_LFO_APPLY: cmd_o.op = OP_APPLY_LFO;
      ST_IDX_MUL:   cmd_o.op = OP_MUL_IDX;
      ST_IDX_APPLY: cmd_o.op = OP_APPLY_IDX;
      ST_G_MUL:     cmd_o.op = OP_MUL_G;
      ST_G_APPLY:   cmd_o.op = OP_APPLY_G;
      ST_Y_MUL:     cmd_o.op = OP_MUL_Y;
      ST_Y_APPLY:   cmd_o.op = OP_APPLY_Y;
      ST_Z_MUL:     cmd_o.op = OP_MUL_Z;
      ST_Z_APPLY:   cmd_o.op = OP_APPLY_Z;
      ST_OUT_MUL:   cmd_o.op = OP_MUL_OUT;
      ST_OUT_APPLY: cmd_o.op = OP_APPLY_OUT;
      ST_DONE:      cmd_o.out_load = out_free;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  // Hold output beat until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (state_q == ST_DONE && out_free) out_valid_d = 1'b1;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/phaser_dp.sv
// ----------------------------------------------------------------------------
// phaser_dp
// Datapath: registers, LFO phases, allpass memories, the sine and
// coefficient tables and one shared signed multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module phaser_dp
  import phaser_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [CFG_W-1:0]           cfg_wdata_i,
  input  wire                        command_i,
  input  wire                        channel_i,
  input  wire  signed [SAMPLE_W-1:0] sample_in_i,
  input  dp_cmd_t                    cmd_i,
  output dp_status_t                 status_o,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  // Configuration
  logic [STEP_W-1:0] lfo_step_q;
  logic [FRAC_W-1:0] sweep_depth_q;
  logic [FRAC_W-1:0] feedback_q;

  // Item and working registers
  logic                       cmd_q;
  logic                       ch_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [PROD_W-1:0]   p_q;
  logic [FRAC_W-1:0]          u_q;
  logic signed [COEF_W-1:0]   coef_q;
  logic [FRAC_W:0]            g_q;
  logic signed [MEM_W-1:0]    y_q;
  logic signed [MEM_W-1:0]    xs_q;
  logic signed [SAMPLE_W-1:0] res_q;
  logic signed [SAMPLE_W-1:0] out_q;

  // State
  logic [PHASE_W-1:0]      phase_q [CHANNELS];
  logic signed [MEM_W-1:0] mem_q   [MEM_N];

  logic [CH_W-1:0]            ch_idx;
  logic [MEM_AW-1:0]          mem_addr;
  logic [PHASE_W+KW:0]        k_prod;
  logic [KW-1:0]              k_idx;
  logic signed [16:0]         lfo_off;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [OPB_W-1:0]    op_b;
  logic signed [PROD_W-1:0]   p_rnd;
  logic signed [PROD_W-16-1:0] p_sh;
  logic [PROD_W-16-1:0]       j_full;
  logic [KW-1:0]              j_idx;
  logic signed [31:0]         y_sum;
  logic signed [31:0]         z_diff;
  logic signed [31:0]         o_sum;

  assign ch_idx   = CH_W'(ch_q);
  assign mem_addr = MEM_AW'(32'(ch_idx) * STAGES + 32'(cmd_i.stage));

  assign status_o.is_clear = cmd_q;
  assign status_o.ch_ok    = (32'(ch_q) < CHANNELS);

  // Sine lookup at the channel phase
  assign k_prod  = (PHASE_W+KW+1)'(phase_q[ch_idx]) * (PHASE_W+KW+1)'(TABLE_ENTRIES);
  assign k_idx   = KW'(k_prod >> PHASE_W);
  assign lfo_off = 17'(SINE_TAB[k_idx]) + 17'sd32768;

  // Rounded Q16 view of the product
  assign p_rnd  = p_q + PROD_W'(32768);
  assign p_sh   = p_rnd[PROD_W-1:16];
  assign j_full = p_sh;
  assign j_idx  = (j_full > (PROD_W-16)'(TABLE_ENTRIES - 1)) ?
                  KW'(TABLE_ENTRIES - 1) : KW'(j_full);

  assign y_sum  = 32'(p_sh) + 32'(mem_q[mem_addr]);
  assign z_diff = 32'(xs_q) - 32'(p_sh);
  assign o_sum  = 32'(x_q) + 32'(p_sh);

  // Select multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd_i.op)
      OP_MUL_LFO: begin
        op_a = OPA_W'({1'b0, sweep_depth_q});
        op_b = OPB_W'(lfo_off);
      end
      OP_MUL_IDX: begin
        op_a = OPA_W'({1'b0, u_q});
        op_b = OPB_W'(TABLE_ENTRIES - 1);
      end
      OP_MUL_G: begin
        op_a = OPA_W'({1'b0, feedback_q});
        op_b = OPB_W'(FB_SCALE);
      end
      OP_MUL_Y: begin
        op_a = y_q;
        op_b = coef_q;
      end
      OP_MUL_Z: begin
        op_a = y_q;
        op_b = coef_q;
      end
      OP_MUL_OUT: begin
        op_a = y_q;
        op_b = OPB_W'({1'b0, g_q});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_step_q    <= '0;
      sweep_depth_q <= '0;
      feedback_q    <= '0;
    end else if (cfg_we_i) begin
      priority case (cfg_idx_i)
        REG_LFO_STEP:    lfo_step_q    <= cfg_wdata_i[STEP_W-1:0];
        REG_SWEEP_DEPTH: sweep_depth_q <= cfg_wdata_i[FRAC_W-1:0];
        REG_FEEDBACK:    feedback_q    <= cfg_wdata_i[FRAC_W-1:0];
        default:         ;
      endcase
    end
  end

  // Advance LFO phase and update allpass memories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) phase_q[c] <= '0;
      for (int m = 0; m < MEM_N; m++) mem_q[m] <= '0;
    end else begin
      if (cmd_i.op == OP_CLEAR) begin
        for (int m = 0; m < MEM_N; m++) mem_q[m] <= '0;
      end
      if (cmd_i.op == OP_APPLY_Z) mem_q[mem_addr] <= sat_mem(z_diff);
      if (cmd_i.op == OP_APPLY_OUT) begin
        phase_q[ch_idx] <= phase_q[ch_idx] + PHASE_W'(lfo_step_q);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        cmd_q <= command_i;
        ch_q  <= channel_i;
        x_q   <= sample_in_i;
      end
      OP_CLEAR, OP_ZERO: res_q <= '0;
      OP_MUL_LFO: begin
        p_q <= op_a * op_b;
        y_q <= MEM_W'(x_q);
      end
      OP_MUL_IDX, OP_MUL_G, OP_MUL_Y, OP_MUL_Z, OP_MUL_OUT: p_q <= op_a * op_b;
      OP_APPLY_LFO: u_q    <= p_q[FRAC_W+15:FRAC_W];
      OP_APPLY_IDX: coef_q <= COEF_TAB[j_idx];
      OP_APPLY_G:   g_q    <= p_sh[FRAC_W:0];
      OP_APPLY_Y: begin
        xs_q <= y_q;
        y_q  <= sat_mem(y_sum);
      end
      OP_APPLY_OUT: res_q <= sat_smp(o_sum);
      default: ;
    endcase
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign sample_out_o = out_q;

endmodule

`default_nettype wire

### hw/rtl/four_stage_allpass_phaser_top.sv
// ----------------------------------------------------------------------------
// four_stage_allpass_phaser_top
// Stereo four-stage allpass phaser on 24-bit samples tagged with a channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (command, channel, sample_in) use in_valid_i / in_ready_o;
//   result beats (sample_out) use out_valid_o / out_ready_i. Each input beat
//   gives exactly one result beat. A clear command zeroes all allpass
//   memories, keeps the LFO phases and returns zero.
//   The user writes configuration through cfg_we_i / cfg_idx_i / cfg_wdata_i,
//   one register per cycle, only while idle; the block does not enforce this.
// Sequence:
//   A sample is worked by one shared 28x18 multiplier, each product in a
//   multiply step and an apply step: LFO, coefficient index, gain, two per
//   allpass stage and the output mix. A new sample is taken only once the
//   sequencer is back in idle after the last one's result step.
//   A clear command skips the multiplier steps.
//   The output register holds one finished beat; the next sample is taken
//   while it waits, and the sequencer holds in its last step only when a
//   second result is ready before the first is taken.
// Reset:
//   Sequencer, config, LFO phases and allpass memories clear to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module four_stage_allpass_phaser_top
  import phaser_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [CFG_W-1:0]           cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        command_i,
  input  wire                        channel_i,
  input  wire  signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  phaser_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  phaser_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .command_i    (command_i),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_out_o (sample_out_o)
  );

`ifndef NO_ASSERTIONS
  // Drop ready right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  // Raise a result only at the end of a busy sequence
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while idle");

  // Load the output register only when the slot is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire
